// ----- hdl/refcounted_lru_cache_policy_macros.svh -----
// assertion macros for the refcounted lru cache policy
// no dependencies; included by files that carry concurrent assertions
`ifndef REFCOUNTED_LRU_CACHE_POLICY_MACROS_SVH
`define REFCOUNTED_LRU_CACHE_POLICY_MACROS_SVH

// property checked every clock outside reset
`define RCLRU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cache policy check failed");

// consequent checked in the cycle after the antecedent
`define RCLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache policy sequence check failed");

`endif

// ----- hdl/rclru_pkg.sv -----
// types, codes and constants of the refcounted lru cache policy
// no dependencies
`default_nettype none

package rclru_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int BYTES_W   = 32;
  localparam int USE_W     = 16;
  localparam int TIME_W    = 32;
  localparam int MODE_W    = 3;
  localparam int ELIM_W    = 5;
  localparam int BLIM_W    = 40;
  localparam int ALIM_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 40;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;

  localparam logic [ELIM_W-1:0] ELIM_RST = ELIM_W'(16);
  localparam logic [BLIM_W-1:0] BLIM_RST = '1;
  localparam logic [ALIM_W-1:0] ALIM_RST = '1;
  localparam logic [USE_W-1:0]  USE_MAX  = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_ACQUIRE = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_SIZE    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_DUP     = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EVICT  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_LIMIT = 2'd0,
    REG_BYTE_LIMIT  = 2'd1,
    REG_AGE_LIMIT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OP,
    S_CULL,
    S_DECIDE,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [USE_W-1:0]   uses;
    logic [TIME_W-1:0]  rtime;
  } entry_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [USE_W-1:0]   uses;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/refcounted_lru_cache_policy.sv -----
// refcounted lru cache policy: request channel in, result channel out, config writes.
// Each request (tuser mode: add, acquire, release, tick, size query) is looked up
// by scanning the slot memory one slot per cycle, then applied with one write back.
// A successful add, a tick and a release to zero then run a cull: each pass scans
// all slots for the idle entry with the oldest release time and evicts it while the
// entry, byte or age limit is exceeded. A request gives one status transfer, then one
// transfer per eviction; tlast marks the final one of the request.
// When a cull runs, the status result leaves after its first pass, and the cull makes
// one pass per eviction plus one, since the slot memory has a single read port.
// Requests are taken one at a time.
// A stalled result channel holds the block until the output register frees up.
// Reset empties the table and loads the limits with 16 entries, all-ones bytes and
// all-ones seconds. Config writes are always ready and belong between requests.
// depends on rclru_pkg, rclru_mem and refcounted_lru_cache_policy_macros.svh
`default_nettype none

module refcounted_lru_cache_policy #(
  parameter int SLOTS = rclru_pkg::SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // entry_key, object_bytes, now_seconds
  input  wire logic [rclru_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // mode
  input  wire logic [rclru_pkg::MODE_W-1:0]    s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // status, result_key, result_bytes, use_count, zero fill
  output logic [rclru_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // kind
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rclru_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rclru_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import rclru_pkg::*;

  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = AW + 1;
  localparam int EW   = $clog2(SLOTS + 1);
  localparam int BHW  = BYTES_W + EW;
  localparam int CMPW = (BHW > BLIM_W) ? BHW : BLIM_W;
  localparam int LW   = (EW > ELIM_W) ? EW : ELIM_W;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [BYTES_W-1:0]  obytes_q, obytes_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [TIME_W-1:0]   latest_q, latest_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_slot_q, rd_slot_d;
  logic                hit_q, hit_d;
  logic [AW-1:0]       hit_slot_q, hit_slot_d;
  entry_t              hit_ent_q, hit_ent_d;
  logic                pick_q, pick_d;
  logic [AW-1:0]       pick_slot_q, pick_slot_d;
  entry_t              pick_ent_q, pick_ent_d;
  logic [SLOTS-1:0]    valid_q, valid_d;
  logic [EW-1:0]       entries_q, entries_d;
  logic [BHW-1:0]      bytes_q, bytes_d;
  logic [ELIM_W-1:0]   elim_q;
  logic [BLIM_W-1:0]   blim_q;
  logic [ALIM_W-1:0]   alim_q;
  result_t             pend_q, pend_d;
  result_t             out_q, out_d;
  logic                out_last_q, out_last_d;
  logic                out_vld_q, out_vld_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  logic [AW-1:0]       mem_raddr;
  entry_t              mem_rdata;

  logic [AW-1:0]       free_slot;
  logic                any_free;
  logic                out_free;
  logic [USE_W-1:0]    new_uses;
  logic                over_limit;

  rclru_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  assign any_free = ~&valid_q;
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    unique case (mode_q) inside
      MODE_ACQUIRE: new_uses = (hit_ent_q.uses == USE_MAX) ? hit_ent_q.uses
                                                           : hit_ent_q.uses + 1'b1;
      MODE_RELEASE: new_uses = (hit_ent_q.uses == '0) ? hit_ent_q.uses
                                                      : hit_ent_q.uses - 1'b1;
      default:      new_uses = hit_ent_q.uses;
    endcase
  end

  assign over_limit = (LW'(entries_q) > LW'(elim_q)) ||
                      (CMPW'(bytes_q) > CMPW'(blim_q)) ||
                      (pick_ent_q.rtime < latest_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    obytes_d    = obytes_q;
    now_d       = now_q;
    latest_d    = latest_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_slot_d   = rd_slot_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_ent_d   = hit_ent_q;
    pick_d      = pick_q;
    pick_slot_d = pick_slot_q;
    pick_ent_d  = pick_ent_q;
    valid_d     = valid_q;
    entries_d   = entries_q;
    bytes_d     = bytes_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    mem_we      = 1'b0;
    mem_waddr   = hit_slot_q;
    mem_wdata   = hit_ent_q;
    mem_raddr   = cnt_q[AW-1:0];
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          mode_d        = s_axis_tuser_i;
          key_d         = s_axis_tdata_i[KEY_W-1:0];
          obytes_d      = s_axis_tdata_i[KEY_W+BYTES_W-1:KEY_W];
          now_d         = s_axis_tdata_i[KEY_W+BYTES_W+TIME_W-1:KEY_W+BYTES_W];
          pend_d        = '{kind: KIND_STATUS, status: ST_OK,
                            key: s_axis_tdata_i[KEY_W-1:0], bytes: '0, uses: '0};
          cnt_d         = '0;
          hit_d         = 1'b0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q < CW'(SLOTS)) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (rd_vld_q && !hit_q && valid_q[rd_slot_q] && (mem_rdata.key == key_q)) begin
          hit_d      = 1'b1;
          hit_slot_d = rd_slot_q;
          hit_ent_d  = mem_rdata;
        end
        if ((cnt_q == CW'(SLOTS)) && !rd_vld_q) begin
          state_d = S_OP;
        end
      end
      S_OP: begin
        latest_d = (now_q < alim_q) ? '0 : now_q - alim_q;
        cnt_d    = '0;
        pick_d   = 1'b0;
        state_d  = S_FLUSH;
        unique case (mode_q) inside
          MODE_ADD: begin
            if (hit_q) begin
              pend_d.status = ST_DUP;
            end else if (!any_free) begin
              pend_d.status = ST_FULL;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = free_slot;
              mem_wdata          = '{key: key_q, bytes: obytes_q, uses: '0, rtime: now_q};
              valid_d[free_slot] = 1'b1;
              entries_d          = entries_q + 1'b1;
              bytes_d            = bytes_q + BHW'(obytes_q);
              pend_d.bytes       = obytes_q;
              state_d            = S_CULL;
            end
          end
          MODE_ACQUIRE, MODE_RELEASE, MODE_SIZE: begin
            if (!hit_q) begin
              pend_d.status = ST_MISSING;
            end else begin
              mem_we         = 1'b1;
              mem_wdata.uses = new_uses;
              pend_d.bytes   = hit_ent_q.bytes;
              pend_d.uses    = new_uses;
              if ((mode_q == MODE_RELEASE) && (new_uses == '0)) begin
                mem_wdata.rtime = now_q;
                state_d         = S_CULL;
              end
            end
          end
          MODE_TICK: state_d = S_CULL;
          default: state_d = S_FLUSH;
        endcase
      end
      S_CULL: begin
        if (cnt_q < CW'(SLOTS)) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (rd_vld_q && valid_q[rd_slot_q] && (mem_rdata.uses == '0) &&
            (!pick_q || (mem_rdata.rtime < pick_ent_q.rtime))) begin
          pick_d      = 1'b1;
          pick_slot_d = rd_slot_q;
          pick_ent_d  = mem_rdata;
        end
        if ((cnt_q == CW'(SLOTS)) && !rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (pick_q && over_limit) begin
          if (out_free) begin
            out_d                = pend_q;
            out_last_d           = 1'b0;
            out_vld_d            = 1'b1;
            pend_d               = '{kind: KIND_EVICT, status: ST_OK, key: pick_ent_q.key,
                                     bytes: pick_ent_q.bytes, uses: '0};
            valid_d[pick_slot_q] = 1'b0;
            entries_d            = entries_q - 1'b1;
            bytes_d              = bytes_q - BHW'(pick_ent_q.bytes);
            cnt_d                = '0;
            pick_d               = 1'b0;
            state_d              = S_CULL;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      entries_q <= '0;
      bytes_q   <= '0;
      out_vld_q <= 1'b0;
      elim_q    <= ELIM_RST;
      blim_q    <= BLIM_RST;
      alim_q    <= ALIM_RST;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      valid_q   <= valid_d;
      entries_q <= entries_d;
      bytes_q   <= bytes_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ENTRY_LIMIT: elim_q <= cfg_data_i[ELIM_W-1:0];
          REG_BYTE_LIMIT:  blim_q <= cfg_data_i[BLIM_W-1:0];
          REG_AGE_LIMIT:   alim_q <= cfg_data_i[ALIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    obytes_q    <= obytes_d;
    now_q       <= now_d;
    latest_q    <= latest_d;
    cnt_q       <= cnt_d;
    rd_slot_q   <= rd_slot_d;
    hit_q       <= hit_d;
    hit_slot_q  <= hit_slot_d;
    hit_ent_q   <= hit_ent_d;
    pick_q      <= pick_d;
    pick_slot_q <= pick_slot_d;
    pick_ent_q  <= pick_ent_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_q.uses, out_q.bytes, out_q.key, out_q.status};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

`include "refcounted_lru_cache_policy_macros.svh"

  `RCLRU_ASSERT(a_count_matches, clk_i, rst_ni, entries_q == EW'($countones(valid_q)))
  `RCLRU_ASSERT(a_evict_idle, clk_i, rst_ni, (out_vld_q && (out_q.kind == KIND_EVICT)) |-> (out_q.uses == '0))
  `RCLRU_ASSERT_NEXT(a_accept_scan, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, state_q == S_SCAN)

endmodule

`default_nettype wire

// ----- hdl/rclru_mem.sv -----
// slot table memory: one write port, one registered read port
// depends on rclru_pkg
`default_nettype none

module rclru_mem #(
  parameter int DEPTH = rclru_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(rclru_pkg::SLOTS_DEF)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  rclru_pkg::entry_t     wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output rclru_pkg::entry_t     rdata_o
);
  import rclru_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- test/tb_refcounted_lru_cache_policy.sv -----
// testbench for the refcounted lru cache policy: random and directed requests,
// results checked against a behavioral model of the slot table held here
// depends on rclru_pkg and refcounted_lru_cache_policy
`default_nettype none

module tb_refcounted_lru_cache_policy;
  timeunit 1ns;
  timeprecision 1ps;
  import rclru_pkg::*;

  localparam int NSLOT = 16;
  localparam int CULL_GAP = 600;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] bytes;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] key;
    logic [31:0] bytes;
    logic [15:0] uses;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [MODE_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  refcounted_lru_cache_policy u_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // model of the slot table
  logic        tbl_valid [NSLOT];
  logic [31:0] tbl_key [NSLOT];
  logic [31:0] tbl_bytes [NSLOT];
  logic [15:0] tbl_uses [NSLOT];
  logic [31:0] tbl_time [NSLOT];
  int unsigned tbl_count;
  logic [39:0] tbl_total;
  logic [4:0]  lim_entries = 5'd16;
  logic [39:0] lim_bytes = '1;
  logic [31:0] lim_age = '1;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   sender_idle_pct = 12;
  int   receiver_idle_pct = 56;
  bit   sender_hold = 1'b0;
  int   errors = 0;
  int   results_seen = 0;
  int   evictions_seen = 0;
  longint cycles = 0;

  function automatic res_t mk(logic kind, logic [1:0] st, logic [31:0] k,
                              logic [31:0] b, logic [15:0] u);
    res_t r;
    r.kind = kind; r.status = st; r.key = k; r.bytes = b; r.uses = u; r.last = 1'b0;
    return r;
  endfunction

  task automatic cull_idle(input logic [31:0] now, inout res_t outs[$]);
    logic [31:0] bound;
    int pick;
    bound = (now < lim_age) ? 32'd0 : now - lim_age;
    forever begin
      pick = -1;
      for (int i = 0; i < NSLOT; i++)
        if (tbl_valid[i] && tbl_uses[i] == 0 &&
            (pick < 0 || tbl_time[i] < tbl_time[pick])) pick = i;
      if (pick < 0) break;
      if (!(lim_entries < tbl_count || lim_bytes < tbl_total || tbl_time[pick] < bound))
        break;
      tbl_valid[pick] = 1'b0;
      tbl_count--;
      tbl_total -= tbl_bytes[pick];
      outs.push_back(mk(KIND_EVICT, ST_OK, tbl_key[pick], tbl_bytes[pick], '0));
    end
  endtask

  task automatic predict_request(input req_t rq);
    res_t outs[$];
    int s;
    int fr;
    s = -1;
    fr = -1;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && tbl_key[i] == rq.key && s < 0) s = i;
    outs.push_back(mk(KIND_STATUS, ST_OK, rq.key, '0, '0));
    case (rq.mode)
      MODE_ADD: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) fr = i;
        if (s >= 0) outs[0].status = ST_DUP;
        else if (fr < 0) outs[0].status = ST_FULL;
        else begin
          tbl_valid[fr] = 1'b1; tbl_key[fr] = rq.key; tbl_bytes[fr] = rq.bytes;
          tbl_uses[fr] = '0; tbl_time[fr] = rq.now;
          tbl_count++; tbl_total += rq.bytes;
          outs[0].bytes = rq.bytes;
          cull_idle(rq.now, outs);
        end
      end
      MODE_ACQUIRE, MODE_RELEASE, MODE_SIZE: begin
        if (s < 0) outs[0].status = ST_MISSING;
        else begin
          if (rq.mode == MODE_ACQUIRE && tbl_uses[s] != USE_MAX) tbl_uses[s]++;
          if (rq.mode == MODE_RELEASE && tbl_uses[s] != 0) tbl_uses[s]--;
          outs[0].bytes = tbl_bytes[s];
          outs[0].uses = tbl_uses[s];
          if (rq.mode == MODE_RELEASE && tbl_uses[s] == 0) begin
            tbl_time[s] = rq.now;
            cull_idle(rq.now, outs);
          end
        end
      end
      MODE_TICK: cull_idle(rq.now, outs);
      default: ;
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  // request driver
  always @(posedge clk_i) begin
    req_t rq;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) begin
          rq.mode = s_axis_tuser_i;
          rq.key = s_axis_tdata_i[31:0];
          rq.bytes = s_axis_tdata_i[63:32];
          rq.now = s_axis_tdata_i[95:64];
          predict_request(rq);
        end
        if (pending_reqs.size() > 0 && !sender_hold &&
            $urandom_range(99, 0) >= sender_idle_pct) begin
          rq = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= rq.mode;
          s_axis_tdata_i <= {rq.now, rq.bytes, rq.key};
        end else s_axis_tvalid_i <= 1'b0;
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      res_t got;
      res_t want;
      got.kind = m_axis_tuser_o;
      got.status = m_axis_tdata_o[1:0];
      got.key = m_axis_tdata_o[33:2];
      got.bytes = m_axis_tdata_o[65:34];
      got.uses = m_axis_tdata_o[81:66];
      got.last = m_axis_tlast_o;
      results_seen++;
      if (got.kind) evictions_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer kind %0d key %h", got.kind, got.key);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, got.kind); errors++;
        end
        if (got.status != want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.key != want.key) begin
          $error("result_key: expected %h actual %h", want.key, got.key); errors++;
        end
        if (got.bytes != want.bytes) begin
          $error("result_bytes: expected %h actual %h", want.bytes, got.bytes); errors++;
        end
        if (got.uses != want.uses) begin
          $error("use_count: expected %0d actual %0d", want.uses, got.uses); errors++;
        end
        if (got.last != want.last) begin
          $error("last: expected %0d actual %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("refcounted_lru_cache_policy regression: fail");
      $finish;
    end
  end

  function automatic req_t rq_of(mode_e m, logic [31:0] k, logic [31:0] b,
                                 logic [31:0] t);
    req_t r;
    r.mode = m; r.key = k; r.bytes = b; r.now = t;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (CULL_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [39:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ENTRY_LIMIT: lim_entries = val[4:0];
      REG_BYTE_LIMIT: lim_bytes = val;
      default: lim_age = val[31:0];
    endcase
    @(posedge clk_i);
  endtask

  // mostly keys from a small pool so adds, acquires and releases meet
  task automatic queue_random(int n, logic [31:0] t0);
    logic [31:0] t;
    req_t r;
    int pick;
    t = t0;
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(40, 0);
      pick = $urandom_range(99, 0);
      r.key = (pick < 85) ? 32'($urandom_range(23, 0)) : $urandom;
      r.mode = (pick < 90) ? 3'($urandom_range(4, 0)) : 3'($urandom_range(7, 0));
      r.bytes = ($urandom_range(3, 0) == 0) ? $urandom : 32'($urandom_range(5000, 0));
      r.now = ($urandom_range(19, 0) == 0) ? $urandom : t;
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    tbl_total = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill past capacity, duplicates, misses, saturation, odd modes
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(rq_of(MODE_ADD, 32'(i), (i == 0) ? '1 : 32'(i * 7), 32'(i)));
    pending_reqs.push_back(rq_of(MODE_ADD, 32'hFFFF_FFFF, 32'd1, 32'd20));
    pending_reqs.push_back(rq_of(MODE_ADD, 32'd3, 32'd1, 32'd20));
    pending_reqs.push_back(rq_of(MODE_ACQUIRE, 32'd2, '0, 32'd21));
    pending_reqs.push_back(rq_of(MODE_SIZE, 32'hDEAD_BEEF, '0, 32'd21));
    pending_reqs.push_back(rq_of(MODE_RELEASE, 32'd2, '0, 32'd22));
    pending_reqs.push_back(rq_of(MODE_RELEASE, 32'd2, '0, 32'hFFFF_FFFF));
    pending_reqs.push_back(rq_of(MODE_TICK, '0, '0, 32'd30));
    pending_reqs.push_back({3'd7, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'h8000_0000});
    sender_hold = 1'b0;
    wait_drained();

    // saturate a use count without waiting 65535 requests: not reachable cheaply,
    // so cover the counter with acquires and releases in the random part
    write_reg(REG_ENTRY_LIMIT, 40'd4);
    write_reg(REG_BYTE_LIMIT, 40'd6000);
    write_reg(REG_AGE_LIMIT, 40'd100);
    queue_random(60, 32'd1000);
    wait_drained();

    sender_idle_pct = 56;
    receiver_idle_pct = 12;
    write_reg(REG_ENTRY_LIMIT, 40'd0);
    write_reg(REG_BYTE_LIMIT, 40'hFF_FFFF_FFFF);
    write_reg(REG_AGE_LIMIT, 40'd0);
    queue_random(25, 32'd5000);
    // pause the sender midway until every expected result has come
    while (pending_reqs.size() > 12) @(posedge clk_i);
    sender_hold = 1'b1;
    while (s_axis_tvalid_i || expected_results.size() > 0) @(posedge clk_i);
    sender_hold = 1'b0;
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_reg(REG_ENTRY_LIMIT, 40'd16);
    write_reg(REG_BYTE_LIMIT, 40'd0);
    write_reg(REG_AGE_LIMIT, 40'hFFFF_FFFF);
    queue_random(15, 32'd9000);
    wait_drained();
    write_reg(REG_ENTRY_LIMIT, 40'd10);
    write_reg(REG_BYTE_LIMIT, 40'd20000);
    write_reg(REG_AGE_LIMIT, 40'd300);
    queue_random(50, 32'h7FFF_0000);
    wait_drained();

    $display("covered adds to a full table, misses, duplicates and culls under limits");
    $display("%0d results checked, %0d evictions", results_seen, evictions_seen);
    if (errors == 0) $display("refcounted_lru_cache_policy regression: pass");
    else $display("refcounted_lru_cache_policy regression: fail");
    $finish;
  end
endmodule

`default_nettype wire
